// ===== rtl/hpg_pkg.sv =====
// Shared constants and types for the Hammersley point generator.
package hpg_pkg;

  localparam int LENGTH_BITS = 21;
  localparam int COORD_BITS  = 32;
  localparam int DIGIT_BITS  = 3;
  localparam int NUM_RADICES = 3;
  localparam int RADIX [NUM_RADICES] = '{2, 3, 5};

  typedef logic [COORD_BITS-1:0] coord_t;

endpackage

// ===== rtl/hammersley_point_generator.sv =====
// Hammersley point generator: regular coordinate and radical inverses in bases 2, 3 and 5.
// An in-range word has its digits extracted by the skewed row of digit cells, then goes through
// the bit-serial dividers, then to the output register; an out-of-range word goes straight to
// the output register. A new word is taken only after the last result is loaded into the output
// register. A result word held by the receiver stalls the next one.
// Reset (synchronous, active low) empties the block and sets the sequence length to 1.
module hammersley_point_generator #(
  parameter int INDEX_BITS    = 20,
  parameter int FRACTION_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hpg_pkg::LENGTH_BITS-1:0]  cfg_sequence_length,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [INDEX_BITS-1:0]            in_sample_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hpg_pkg::COORD_BITS-1:0]   out_regular_coord,
  output logic [hpg_pkg::COORD_BITS-1:0]   out_radix2_coord,
  output logic [hpg_pkg::COORD_BITS-1:0]   out_radix3_coord,
  output logic [hpg_pkg::COORD_BITS-1:0]   out_radix5_coord,
  output logic                             out_index_out_of_range
);
  import hpg_pkg::*;

  localparam int DIG_N   = INDEX_BITS + 1;
  localparam int SCL_W   = INDEX_BITS + 3;
  localparam int REG_W   = LENGTH_BITS + 1;
  localparam int CMP_W   = (INDEX_BITS > LENGTH_BITS) ? INDEX_BITS : LENGTH_BITS;
  localparam int CNT_MAX = (2 * DIG_N > FRACTION_BITS) ? 2 * DIG_N : FRACTION_BITS;
  localparam int CNT_W   = $clog2(CNT_MAX);
  localparam int IDX_W   = $clog2(DIG_N);
  localparam int DSUM_W  = DIGIT_BITS + 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_EXTRACT = 2'd1;
  localparam logic [1:0] ST_DIVIDE  = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  logic [1:0]             state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [DIG_N-1:0]       m_r;
  logic                   oor_r;
  logic                   out_valid_r;
  coord_t                 out_regular_r;
  coord_t                 out_radix_r [NUM_RADICES];
  logic                   out_oor_r;

  logic                   in_acc;
  logic                   oor;
  logic                   feed_v;
  logic                   horner_phase;
  logic                   load_out;
  logic [CNT_W-1:0]       hsub;
  logic [IDX_W-1:0]       hidx;

  logic [REG_W-1:0]       reg_rem_r;
  coord_t                 reg_quo_r;
  logic [REG_W:0]         reg_sh;
  logic [REG_W:0]         reg_den;
  coord_t                 rad_quo [NUM_RADICES];

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state_r == ST_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign oor          = CMP_W'(in_sample_index) >= CMP_W'(len_r);
  assign feed_v       = (state_r == ST_EXTRACT) && (cnt_r < CNT_W'(DIG_N));
  assign horner_phase = (state_r == ST_EXTRACT) && (cnt_r >= CNT_W'(DIG_N));
  assign hsub         = cnt_r - CNT_W'(DIG_N);
  assign hidx         = hsub[IDX_W-1:0];
  assign load_out     = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Sequencer: digit extraction, fraction divisions, output stage; out of range: output only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      len_r       <= LENGTH_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_sequence_length;
      end
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cnt_r   <= '0;
            state_r <= oor ? ST_DONE : ST_EXTRACT;
          end
        end
        ST_EXTRACT: begin
          if (cnt_r == CNT_W'(2 * DIG_N - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DIVIDE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_DIVIDE: begin
          if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // The index plus one is fed into the digit cells most significant bit first.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_r   <= DIG_N'(in_sample_index) + DIG_N'(1);
      oor_r <= oor;
    end else if (state_r == ST_EXTRACT) begin
      m_r <= {m_r[DIG_N-2:0], 1'b0};
    end
  end

  // Regular coordinate: (2i+1) / 2N, one quotient bit per cycle.
  assign reg_sh  = {reg_rem_r, 1'b0};
  assign reg_den = {1'b0, len_r, 1'b0};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      reg_rem_r <= REG_W'({in_sample_index, 1'b1});
      reg_quo_r <= '0;
    end else if (state_r == ST_DIVIDE) begin
      if (reg_sh >= reg_den) begin
        reg_rem_r <= REG_W'(reg_sh - reg_den);
        reg_quo_r <= {reg_quo_r[COORD_BITS-2:0], 1'b1};
      end else begin
        reg_rem_r <= reg_sh[REG_W-1:0];
        reg_quo_r <= {reg_quo_r[COORD_BITS-2:0], 1'b0};
      end
    end
  end

  for (genvar g = 0; g < NUM_RADICES; g++) begin : g_radix
    localparam int BASE = RADIX[g];
    localparam logic [DSUM_W-1:0] BASE_D = DSUM_W'(BASE);
    localparam logic [SCL_W-1:0]  BASE_S = SCL_W'(BASE);

    logic [DIGIT_BITS-1:0] cell_rem_r [DIG_N];
    logic [DIG_N-1:0]      cell_q_r;
    logic [DIG_N-1:0]      cell_v_r;
    logic [DIG_N-1:0]      cell_nz_r;
    logic [DIG_N-1:0]      bit_in;
    logic [DIG_N-1:0]      v_in;
    logic [DIG_N-1:0]      q_nxt;
    logic [DIGIT_BITS-1:0] rem_nxt [DIG_N];
    logic [DSUM_W-1:0]     part [DIG_N];

    logic [SCL_W-1:0]      mir_r;
    logic [SCL_W-1:0]      scl_r;
    logic [SCL_W-1:0]      rem_r;
    coord_t                quo_r;
    logic [SCL_W-1:0]      mir_nxt;
    logic [SCL_W-1:0]      scl_nxt;
    logic [SCL_W:0]        div_sh;
    logic [SCL_W:0]        div_den;
    logic                  take_digit;

    // Each cell divides the quotient stream of the cell before it by the base, one bit a
    // cycle; the remainder left in cell k is digit k of the index plus one.
    assign bit_in = {cell_q_r[DIG_N-2:0], m_r[DIG_N-1]};
    assign v_in   = {cell_v_r[DIG_N-2:0], feed_v};

    always_comb begin
      for (int k = 0; k < DIG_N; k++) begin
        part[k] = {cell_rem_r[k], bit_in[k]};
        if (part[k] >= BASE_D) begin
          q_nxt[k]   = 1'b1;
          rem_nxt[k] = DIGIT_BITS'(part[k] - BASE_D);
        end else begin
          q_nxt[k]   = 1'b0;
          rem_nxt[k] = part[k][DIGIT_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cell_q_r  <= '0;
        cell_v_r  <= '0;
        cell_nz_r <= '0;
      end else if (in_acc) begin
        cell_q_r  <= '0;
        cell_v_r  <= '0;
        cell_nz_r <= '0;
        for (int k = 0; k < DIG_N; k++) begin
          cell_rem_r[k] <= '0;
        end
      end else begin
        for (int k = 0; k < DIG_N; k++) begin
          if (v_in[k]) begin
            cell_rem_r[k] <= rem_nxt[k];
            cell_nz_r[k]  <= cell_nz_r[k] | bit_in[k];
          end
        end
        cell_q_r <= q_nxt & v_in;
        cell_v_r <= v_in;
      end
    end

    // Digits are mirrored one per cycle as their cells finish; a cell whose input was all
    // zeros lies beyond the top digit and is skipped.
    assign take_digit = horner_phase && cell_nz_r[hidx];
    assign mir_nxt    = take_digit ? (mir_r * BASE_S) + SCL_W'(cell_rem_r[hidx]) : mir_r;
    assign scl_nxt    = take_digit ? (scl_r * BASE_S) : scl_r;
    assign div_sh     = {rem_r, 1'b0};
    assign div_den    = {1'b0, scl_r};

    always_ff @(posedge clk) begin
      if (in_acc) begin
        mir_r <= '0;
        scl_r <= SCL_W'(1);
        quo_r <= '0;
      end else if (state_r == ST_EXTRACT) begin
        mir_r <= mir_nxt;
        scl_r <= scl_nxt;
        rem_r <= mir_nxt;
      end else if (state_r == ST_DIVIDE) begin
        if (div_sh >= div_den) begin
          rem_r <= SCL_W'(div_sh - div_den);
          quo_r <= {quo_r[COORD_BITS-2:0], 1'b1};
        end else begin
          rem_r <= div_sh[SCL_W-1:0];
          quo_r <= {quo_r[COORD_BITS-2:0], 1'b0};
        end
      end
    end

    assign rad_quo[g] = quo_r;
  end

  // Output register: frees the datapath while the result word waits to be taken.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_regular_r <= oor_r ? '0 : reg_quo_r;
      for (int g = 0; g < NUM_RADICES; g++) begin
        out_radix_r[g] <= oor_r ? '0 : rad_quo[g];
      end
      out_oor_r <= oor_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_regular_coord      = out_regular_r;
  assign out_radix2_coord       = out_radix_r[0];
  assign out_radix3_coord       = out_radix_r[1];
  assign out_radix5_coord       = out_radix_r[2];
  assign out_index_out_of_range = out_oor_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Hammersley point generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpg_pkg::*;

  localparam int IDX_W = 20;
  localparam int FRAC_W = 32;
  localparam logic [IDX_W-1:0] INDEX_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
  localparam int SWEEP_PHASES = 13;
  localparam int SWEEP_WORDS = 110;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    coord_t regular;
    coord_t radix2;
    coord_t radix3;
    coord_t radix5;
    logic   out_of_range;
  } hpg_point_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LENGTH_BITS-1:0] cfg_sequence_length = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_sample_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_regular_coord;
  coord_t out_radix2_coord;
  coord_t out_radix3_coord;
  coord_t out_radix5_coord;
  logic out_index_out_of_range;

  hpg_point_t pending_points[$];
  logic [LENGTH_BITS-1:0] seq_length = 1;
  int unsigned mismatch_count = 0;
  int unsigned ready_stall = 0;
  logic no_idle = 1'b0;

  hammersley_point_generator #(
    .INDEX_BITS(IDX_W),
    .FRACTION_BITS(FRAC_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_sequence_length(cfg_sequence_length),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_index(in_sample_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_regular_coord(out_regular_coord),
    .out_radix2_coord(out_radix2_coord),
    .out_radix3_coord(out_radix3_coord),
    .out_radix5_coord(out_radix5_coord),
    .out_index_out_of_range(out_index_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact floor of num / den as a Q0.32 fraction; num < den < 2^22 keeps it in 64 bits.
  function automatic coord_t floor_fraction(input longint unsigned num,
                                            input longint unsigned den);
    return coord_t'((num << FRAC_W) / den);
  endfunction

  // The digits of m are mirrored about the radix point.
  function automatic coord_t mirror_fraction(input longint unsigned m,
                                             input longint unsigned base);
    longint unsigned mirrored;
    longint unsigned scale;
    mirrored = 0;
    scale = 1;
    while (m > 0) begin
      mirrored = mirrored * base + m % base;
      m = m / base;
      scale = scale * base;
    end
    return floor_fraction(mirrored, scale);
  endfunction

  function automatic hpg_point_t predict_point(input logic [IDX_W-1:0] idx);
    hpg_point_t pt;
    longint unsigned i;
    i = idx;
    if (i >= seq_length) begin
      pt = '{regular: '0, radix2: '0, radix3: '0, radix5: '0, out_of_range: 1'b1};
    end else begin
      pt.regular = floor_fraction(2 * i + 1, 2 * longint'(seq_length));
      pt.radix2 = mirror_fraction(i + 1, 2);
      pt.radix3 = mirror_fraction(i + 1, 3);
      pt.radix5 = mirror_fraction(i + 1, 5);
      pt.out_of_range = 1'b0;
    end
    return pt;
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r;
    longint near;
    r = $urandom_range(0, 99);
    if (seq_length == 0 || r < 15) return IDX_W'($urandom);
    if (r < 25) begin
      near = longint'(seq_length) + $urandom_range(0, 3) - 2;
      if (near < 0) near = 0;
      if (near > INDEX_MAX) near = INDEX_MAX;
      return IDX_W'(near);
    end
    return IDX_W'($urandom_range(0, (seq_length > INDEX_MAX) ? INDEX_MAX : seq_length - 1));
  endfunction

  function automatic void check_field(input string name, input coord_t exp_val,
                                      input coord_t act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // The receiver stalls independently of the result timing.
  always @(posedge clk) begin
    if (ready_stall != 0) begin
      out_ready <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready <= 1'b1;
      ready_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    hpg_point_t exp_pt;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result word, regular %h", $time, out_regular_coord);
        mismatch_count++;
      end else begin
        exp_pt = pending_points.pop_front();
        check_field("regular_coord", exp_pt.regular, out_regular_coord);
        check_field("radix2_coord", exp_pt.radix2, out_radix2_coord);
        check_field("radix3_coord", exp_pt.radix3, out_radix3_coord);
        check_field("radix5_coord", exp_pt.radix5, out_radix5_coord);
        check_field("index_out_of_range", coord_t'(exp_pt.out_of_range),
                    coord_t'(out_index_out_of_range));
      end
    end
  end

  // Called just after a rising edge. With no gap, valid is left high for the next word.
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int unsigned gap;
    in_valid <= 1'b1;
    in_sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_points.push_back(predict_point(idx));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LENGTH_BITS-1:0] len);
    drain_points();
    cfg_valid <= 1'b1;
    cfg_sequence_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seq_length = len;
  endtask

  task automatic test_reset_length();
    send_index(0);
    send_index(1);
    send_index(INDEX_MAX);
  endtask

  // A zero length puts every index out of range.
  task automatic test_zero_length();
    write_length(0);
    send_index(0);
    send_index(1);
    send_index(INDEX_MAX);
  endtask

  task automatic test_length_boundary();
    write_length(1000);
    send_index(999);
    send_index(1000);
    send_index(0);
  endtask

  task automatic test_index_extremes();
    logic [IDX_W-1:0] picks [12];
    picks = '{0, 1, 2, 3, 4, 8, 24, 124, 20'h55555, 20'hAAAAA, 20'h7FFFF, INDEX_MAX};
    write_length(LENGTH_MAX);
    foreach (picks[k]) send_index(picks[k]);
  endtask

  task automatic test_random_sweep();
    logic [LENGTH_BITS-1:0] len;
    for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
      unique case (phase)
        0: begin
          len = 1;
        end
        1: begin
          len = LENGTH_MAX;
        end
        2: begin
          len = LENGTH_BITS'(1 << IDX_W);
        end
        3: begin
          len = 0;
        end
        4: begin
          len = 2;
        end
        default: begin
          len = ($urandom_range(0, 1) != 0) ? LENGTH_BITS'($urandom_range(1, 4096))
                                            : LENGTH_BITS'($urandom_range(1, LENGTH_MAX));
        end
      endcase
      write_length(len);
      no_idle = (phase % 4 == 2);
      for (int n = 0; n < SWEEP_WORDS; n++) begin
        // The sender now and then waits for every outstanding result.
        if (phase % 2 == 1 && n == SWEEP_WORDS / 2) drain_points();
        send_index(pick_index());
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_length();
    test_zero_length();
    test_length_boundary();
    test_index_extremes();
    test_random_sweep();
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hammersley_point_generator verification clean");
    end else begin
      $display("hammersley_point_generator verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, pending_points.size());
    $display("hammersley_point_generator verification failed");
    $finish;
  end

endmodule
